// ----- rtl/core/dkrs_pkg.sv -----
// Shared types and constants for the dense keyed record store.
// Holds the beat structs, operation and status codes and the module-to-module structs.
// Depends on nothing.
package dkrs_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 32;
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_ERASE  = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [31:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_handle;
    logic [5:0]  slot;
    logic [6:0]  entries;
  } out_item_t;

  // Write into one slot of the array.
  typedef struct packed {
    logic                   en;
    logic [SLOT_W-1:0]      idx;
    logic [63:0]            key;
    logic [HANDLE_BITS-1:0] handle;
  } slot_wr_t;

  // Search result and the contents of the last filled slot.
  typedef struct packed {
    logic                   hit;
    logic [SLOT_W-1:0]      hit_slot;
    logic [HANDLE_BITS-1:0] hit_handle;
    logic [63:0]            last_key;
    logic [HANDLE_BITS-1:0] last_handle;
  } slot_rd_t;

endpackage

// ----- rtl/core/dkrs_in_stage.sv -----
// Input register of the record store: holds one accepted beat until the core takes it.
// Depends on dkrs_pkg.
module dkrs_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dkrs_pkg::in_item_t in_data,
  output logic              item_valid,
  output dkrs_pkg::in_item_t item_data,
  input  logic              item_take
);

  logic               valid_r, valid_nxt;
  dkrs_pkg::in_item_t data_r;

  assign in_stall   = valid_r && !item_take;
  assign item_valid = valid_r;
  assign item_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && !in_stall) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data;
    end
  end

endmodule

// ----- rtl/core/dkrs_slot_array.sv -----
// Row of record cells: key and handle registers, a key comparator per cell and
// one-hot read buses for the matching cell and the last filled cell. Depends on dkrs_pkg.
module dkrs_slot_array (
  input  logic                          clk,
  input  logic [dkrs_pkg::CNT_W-1:0]    count,
  input  logic [63:0]                   search_key,
  input  dkrs_pkg::slot_wr_t            wr,
  output dkrs_pkg::slot_rd_t            rd
);

  logic [63:0]                      key_r    [dkrs_pkg::CAPACITY];
  logic [dkrs_pkg::HANDLE_BITS-1:0] handle_r [dkrs_pkg::CAPACITY];
  logic [dkrs_pkg::CAPACITY-1:0]    hit_vec;
  logic [dkrs_pkg::CAPACITY-1:0]    last_vec;
  logic [dkrs_pkg::CNT_W-1:0]       last_idx;

  assign last_idx = count - dkrs_pkg::CNT_W'(1);

  // Only filled cells take part, so an unwritten cell never contributes.
  always_comb begin
    for (int i = 0; i < dkrs_pkg::CAPACITY; i++) begin
      hit_vec[i]  = (dkrs_pkg::CNT_W'(i) < count) && (key_r[i] == search_key);
      last_vec[i] = (count != '0) && (dkrs_pkg::CNT_W'(i) == last_idx);
    end
  end

  // Keys are unique among filled cells, so the hit vector is one-hot or empty
  // and an AND-OR reduction reads the matching cell.
  always_comb begin
    rd = '0;
    for (int i = 0; i < dkrs_pkg::CAPACITY; i++) begin
      if (hit_vec[i]) begin
        rd.hit        = 1'b1;
        rd.hit_slot   = rd.hit_slot | dkrs_pkg::SLOT_W'(i);
        rd.hit_handle = rd.hit_handle | handle_r[i];
      end
      if (last_vec[i]) begin
        rd.last_key    = rd.last_key | key_r[i];
        rd.last_handle = rd.last_handle | handle_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < dkrs_pkg::CAPACITY; i++) begin
      if (wr.en && (wr.idx == dkrs_pkg::SLOT_W'(i))) begin
        key_r[i]    <= wr.key;
        handle_r[i] <= wr.handle;
      end
    end
  end

endmodule

// ----- rtl/core/dense_keyed_record_store_unit.sv -----
// Top level of the dense keyed record store: operation decode, fill count and result register.
// Depends on dkrs_pkg, dkrs_in_stage and dkrs_slot_array.
//
// The store keeps up to CAPACITY records (64-bit key plus handle) packed in
// slots 0 to count-1. Each input beat on in_data carries one operation:
// insert appends a record, erase moves the last record into the freed slot,
// lookup returns the handle and slot of a key. Every input beat yields
// exactly one result beat on out_data, in order.
// A beat accepted from in_data lands in the input register. Once the result register
// is empty or being taken, the operation is performed against all slots at once and
// its result is loaded into the result register, which raises out_valid until the
// result is taken. One operation completes per cycle while out_stall does not hold it back:
// the key comparators of all cells work in parallel, and the cell write and
// count update happen at the same edge as the result.
// When the receiver holds out_stall, the result register keeps its beat, the
// input register fills, and in_stall rises until the result is taken.
// Reset clears the fill count and both valid flags; the record cells are not
// cleared, since only filled slots are ever searched or read.
module dense_keyed_record_store_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dkrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dkrs_pkg::out_item_t out_data
);

  logic                          item_valid;
  dkrs_pkg::in_item_t            item;
  logic                          item_take;
  dkrs_pkg::slot_wr_t            wr;
  dkrs_pkg::slot_rd_t            rd;
  logic [dkrs_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                          out_valid_r, out_valid_nxt;
  dkrs_pkg::out_item_t           out_data_r, res;
  logic                          full;
  logic [dkrs_pkg::HANDLE_BITS-1:0] new_handle;

  dkrs_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_data  (item),
    .item_take  (item_take)
  );

  dkrs_slot_array u_slot_array (
    .clk        (clk),
    .count      (count_r),
    .search_key (item.key),
    .wr         (wr),
    .rd         (rd)
  );

  assign item_take  = item_valid && (!out_valid_r || !out_stall);
  assign full       = (count_r == dkrs_pkg::CNT_W'(dkrs_pkg::CAPACITY));
  assign new_handle = dkrs_pkg::HANDLE_BITS'(item.handle);

  always_comb begin
    res              = '0;
    res.status       = dkrs_pkg::ST_NOT_FOUND;
    wr               = '0;
    wr.key           = item.key;
    wr.handle        = new_handle;
    wr.idx           = count_r[dkrs_pkg::SLOT_W-1:0];
    count_nxt        = count_r;
    unique case (item.func)
      dkrs_pkg::FN_INSERT: begin
        if (rd.hit) begin
          res.status = dkrs_pkg::ST_DUPLICATE;
          res.slot   = 6'(rd.hit_slot);
        end else if (full) begin
          res.status = dkrs_pkg::ST_FULL;
        end else begin
          res.status       = dkrs_pkg::ST_OK;
          res.slot         = 6'(count_r[dkrs_pkg::SLOT_W-1:0]);
          res.found_handle = 32'(new_handle);
          wr.en            = 1'b1;
          count_nxt        = count_r + dkrs_pkg::CNT_W'(1);
        end
      end
      dkrs_pkg::FN_ERASE: begin
        if (rd.hit) begin
          // Erasing the last record rewrites that cell with itself; harmless.
          res.status       = dkrs_pkg::ST_OK;
          res.slot         = 6'(rd.hit_slot);
          res.found_handle = 32'(rd.hit_handle);
          wr.en            = 1'b1;
          wr.idx           = rd.hit_slot;
          wr.key           = rd.last_key;
          wr.handle        = rd.last_handle;
          count_nxt        = count_r - dkrs_pkg::CNT_W'(1);
        end
      end
      dkrs_pkg::FN_LOOKUP: begin
        if (rd.hit) begin
          res.status       = dkrs_pkg::ST_OK;
          res.slot         = 6'(rd.hit_slot);
          res.found_handle = 32'(rd.hit_handle);
        end
      end
      default: begin
        res.status = dkrs_pkg::ST_NOT_FOUND;
      end
    endcase
    res.entries = 7'(count_nxt);
    if (!item_take) begin
      wr.en     = 1'b0;
      count_nxt = count_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (item_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dkrs_pkg::CNT_W'(dkrs_pkg::CAPACITY))
    else $error("fill count beyond capacity");

  a_stalled_store_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(count_r))
    else $error("store changed while result beat was stalled");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && (item.func == dkrs_pkg::FN_INSERT) && (res.status == dkrs_pkg::ST_OK)
    |=> count_r == $past(count_r) + dkrs_pkg::CNT_W'(1))
    else $error("successful insert did not grow the store");

  a_result_entries: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |=> out_data_r.entries == 7'(count_r))
    else $error("result entry count disagrees with the fill count");

endmodule

// ----- sim/dense_keyed_record_store_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench for dense_keyed_record_store_unit: directed and random insert, erase and lookup
// beats, each result checked against an in-bench model of the packed slot store.
// Depends on dkrs_pkg and the RTL of the unit.
module dense_keyed_record_store_unit_tb;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int POOL_SIZE = 96;
  localparam int CLK_HALF  = 2;
  localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  dkrs_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dkrs_pkg::out_item_t out_data;

  // Model of the store, updated as each input beat is accepted.
  logic [63:0]                      model_keys    [dkrs_pkg::CAPACITY];
  logic [dkrs_pkg::HANDLE_BITS-1:0] model_handles [dkrs_pkg::CAPACITY];
  int model_count = 0;
  int peak_count  = 0;

  dkrs_pkg::out_item_t pending_results[$];
  dkrs_pkg::out_item_t predicted_result;
  dkrs_pkg::out_item_t next_expected;
  logic [63:0] key_pool [POOL_SIZE];
  int          error_count = 0;
  int          status_seen [4] = '{default: 0};
  stall_mode_t stall_mode = STALL_NONE;
  int          hold_left  = 0;
  int          stall_tick = 0;
  bit          sender_gaps_on = 1'b0;
  int          burst_left = 0;

  dense_keyed_record_store_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic dkrs_pkg::out_item_t apply_store_op(dkrs_pkg::in_item_t op);
    dkrs_pkg::out_item_t res;
    int hit;
    int last;
    res = '0;
    res.status = dkrs_pkg::ST_NOT_FOUND;
    hit = -1;
    for (int i = 0; i < model_count; i++) begin
      if (hit < 0 && model_keys[i] == op.key) hit = i;
    end
    case (op.func)
      dkrs_pkg::FN_INSERT: begin
        // A duplicate is reported even when the store is full.
        if (hit >= 0) begin
          res.status = dkrs_pkg::ST_DUPLICATE;
          res.slot   = 6'(hit);
        end else if (model_count >= dkrs_pkg::CAPACITY) begin
          res.status = dkrs_pkg::ST_FULL;
        end else begin
          model_keys[model_count]    = op.key;
          model_handles[model_count] = op.handle;
          res.status       = dkrs_pkg::ST_OK;
          res.found_handle = op.handle;
          res.slot         = 6'(model_count);
          model_count++;
        end
      end
      dkrs_pkg::FN_ERASE: begin
        if (hit >= 0) begin
          last = model_count - 1;
          res.status       = dkrs_pkg::ST_OK;
          res.found_handle = model_handles[hit];
          res.slot         = 6'(hit);
          // The last record fills the hole unless it is the one removed.
          if (hit < last) begin
            model_keys[hit]    = model_keys[last];
            model_handles[hit] = model_handles[last];
          end
          model_count = last;
        end
      end
      dkrs_pkg::FN_LOOKUP: begin
        if (hit >= 0) begin
          res.status       = dkrs_pkg::ST_OK;
          res.found_handle = model_handles[hit];
          res.slot         = 6'(hit);
        end
      end
      default: ;
    endcase
    res.entries = 7'(model_count);
    if (model_count > peak_count) peak_count = model_count;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predicted_result = apply_store_op(in_data);
      pending_results  = {pending_results, predicted_result};
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result beat with nothing expected: %p", $time, out_data);
        error_count++;
      end else begin
        next_expected = pending_results.pop_front();
        status_seen[next_expected.status]++;
        check_field("status", next_expected.status, out_data.status);
        check_field("found_handle", next_expected.found_handle, out_data.found_handle);
        check_field("slot", next_expected.slot, out_data.slot);
        check_field("entries", next_expected.entries, out_data.entries);
      end
    end
  end

  // Receiver: a long hold when one is requested, otherwise the current stall pattern.
  always @(negedge clk) begin
    stall_tick++;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 35);
        STALL_PATTERN: out_stall <= ((stall_tick % 11) < 4);
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  // Valid stays high after the beat is taken; the next send or a drain lowers or reuses it.
  task automatic send_op(logic [1:0] fn, logic [63:0] k, logic [31:0] h);
    int gap;
    if (sender_gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= {fn, k, h};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly keys that are stored or drawn from a small reused pool, so hits and duplicates are common.
  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55 && model_count > 0) return model_keys[$urandom_range(0, model_count - 1)];
    if (r < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic send_random_op(int insert_pct, int erase_pct);
    int r;
    logic [1:0] fn;
    r = $urandom_range(0, 99);
    if (r < insert_pct) fn = dkrs_pkg::FN_INSERT;
    else if (r < insert_pct + erase_pct) fn = dkrs_pkg::FN_ERASE;
    else if (r < 96) fn = dkrs_pkg::FN_LOOKUP;
    else fn = FN_UNUSED;
    send_op(fn, pick_key(), $urandom);
  endtask

  task automatic test_single_ops();
    logic [63:0] key_a;
    logic [63:0] key_b;
    key_a = 64'h8000_0000_0000_0001;
    key_b = 64'h5555_AAAA_5555_AAAA;
    send_op(dkrs_pkg::FN_LOOKUP, key_a, $urandom);
    send_op(dkrs_pkg::FN_ERASE, key_a, $urandom);
    send_op(dkrs_pkg::FN_INSERT, 64'h0, 32'h0);
    send_op(dkrs_pkg::FN_INSERT, KEY_ONES, 32'hFFFF_FFFF);
    send_op(dkrs_pkg::FN_INSERT, 64'h0, 32'h1234_5678);
    send_op(dkrs_pkg::FN_LOOKUP, KEY_ONES, $urandom);
    send_op(dkrs_pkg::FN_LOOKUP, 64'h0, $urandom);
    send_op(FN_UNUSED, 64'h0, 32'hFFFF_FFFF);
    send_op(dkrs_pkg::FN_INSERT, key_a, 32'h8000_0001);
    send_op(dkrs_pkg::FN_ERASE, 64'h0, $urandom);
    send_op(dkrs_pkg::FN_LOOKUP, key_a, $urandom);
    send_op(dkrs_pkg::FN_ERASE, KEY_ONES, $urandom);
    send_op(dkrs_pkg::FN_LOOKUP, KEY_ONES, $urandom);
    send_op(dkrs_pkg::FN_ERASE, key_a, $urandom);
    send_op(dkrs_pkg::FN_LOOKUP, key_a, $urandom);
    send_op(FN_UNUSED, KEY_ONES, $urandom);
    // Keys one bit away from a stored key must miss.
    send_op(dkrs_pkg::FN_INSERT, key_b, 32'hA5A5_5A5A);
    send_op(dkrs_pkg::FN_LOOKUP, key_b ^ 64'h1, $urandom);
    send_op(dkrs_pkg::FN_LOOKUP, key_b ^ 64'h8000_0000_0000_0000, $urandom);
    send_op(dkrs_pkg::FN_ERASE, key_b, $urandom);
    wait_results_drained();
  endtask

  // The directed test leaves the store empty, so this fills every slot.
  task automatic test_capacity();
    logic [63:0] fill_keys [dkrs_pkg::CAPACITY];
    for (int i = 0; i < dkrs_pkg::CAPACITY; i++) begin
      fill_keys[i] = {$urandom, 26'($urandom), 6'(i)};
      send_op(dkrs_pkg::FN_INSERT, fill_keys[i], $urandom);
    end
    send_op(dkrs_pkg::FN_INSERT, {$urandom, $urandom}, $urandom);
    send_op(dkrs_pkg::FN_INSERT, fill_keys[5], $urandom);
    send_op(dkrs_pkg::FN_LOOKUP, fill_keys[dkrs_pkg::CAPACITY - 1], $urandom);
    send_op(dkrs_pkg::FN_ERASE, fill_keys[10], $urandom);
    send_op(dkrs_pkg::FN_LOOKUP, fill_keys[dkrs_pkg::CAPACITY - 1], $urandom);
    send_op(dkrs_pkg::FN_INSERT, {$urandom, $urandom}, $urandom);
    send_op(dkrs_pkg::FN_INSERT, {$urandom, $urandom}, $urandom);
    send_op(dkrs_pkg::FN_ERASE, fill_keys[0], $urandom);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    sender_gaps_on = 1'b0;
    stall_mode     = STALL_NONE;
    hold_left      = 80;
    repeat (30) send_random_op(35, 30);
    wait_results_drained();
    sender_gaps_on = 1'b1;
    stall_mode     = STALL_RANDOM;
    hold_left      = 50;
    repeat (30) send_random_op(35, 30);
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int insert_pct;
    int erase_pct;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin sender_gaps_on = 1'b0; stall_mode = STALL_NONE;    end
        1: begin sender_gaps_on = 1'b1; stall_mode = STALL_RANDOM;  end
        2: begin sender_gaps_on = 1'b0; stall_mode = STALL_PATTERN; end
        default: begin sender_gaps_on = 1'b1; stall_mode = STALL_PATTERN; end
      endcase
      // Alternate growing, shrinking and steady phases so the fill level sweeps its range.
      case (phase % 3)
        0: begin insert_pct = 60; erase_pct = 15; end
        1: begin insert_pct = 15; erase_pct = 60; end
        default: begin insert_pct = 35; erase_pct = 30; end
      endcase
      repeat (140) send_random_op(insert_pct, erase_pct);
      if (phase % 2 == 1) wait_results_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_single_ops();
    test_capacity();
    test_backpressure();
    test_random_traffic();
    wait_results_drained();
    stall_mode = STALL_NONE;
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    $display("Checked %0d result beats: %0d ok, %0d missing key, %0d duplicate, %0d full.",
             status_seen[dkrs_pkg::ST_OK] + status_seen[dkrs_pkg::ST_NOT_FOUND]
             + status_seen[dkrs_pkg::ST_DUPLICATE] + status_seen[dkrs_pkg::ST_FULL],
             status_seen[dkrs_pkg::ST_OK], status_seen[dkrs_pkg::ST_NOT_FOUND],
             status_seen[dkrs_pkg::ST_DUPLICATE], status_seen[dkrs_pkg::ST_FULL]);
    $display("Fill level peaked at %0d of %0d slots, with long receiver holds and sender gaps.",
             peak_count, dkrs_pkg::CAPACITY);
    if (error_count == 0) begin
      $display("dense_keyed_record_store_unit_tb: done, clean");
    end else begin
      $display("dense_keyed_record_store_unit_tb: done, errors");
    end
    $finish;
  end

  // Well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("%0t ns: timeout with %0d results outstanding", $time, pending_results.size());
    $display("dense_keyed_record_store_unit_tb: done, errors");
    $finish;
  end

endmodule
